>>> sv/isc_pkg.sv
package isc_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int STORE_DEPTH  = 64;
    localparam int IDX_W        = $clog2(STORE_DEPTH);
    localparam int CNT_W        = IDX_W + 1;
    localparam int DATA_W       = 32;
    localparam int TOT_W        = 12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_PLACE,
        ST_EMIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic cmp_inc;
        logic mov_inc;
        logic ovf_set;
        logic clear;
    } stats_ctl_t;

endpackage

>>> sv/isc_ram.sv
module isc_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/isc_stats.sv
module isc_stats (
    input  logic                    clk,
    input  logic                    rst_n,
    input  isc_pkg::stats_ctl_t     ctl,
    output logic [isc_pkg::TOT_W-1:0] compare_total,
    output logic [isc_pkg::TOT_W-1:0] move_total,
    output logic                    overflow
);
    import isc_pkg::*;

    localparam logic [TOT_W-1:0] TOT_MAX = '1;

    logic [TOT_W-1:0] cmp_reg, cmp_next;
    logic [TOT_W-1:0] mov_reg, mov_next;
    logic             ovf_reg, ovf_next;

    always_comb
    begin
        cmp_next = cmp_reg;
        mov_next = mov_reg;
        ovf_next = ovf_reg;
        if (ctl.clear)
        begin
            cmp_next = '0;
            mov_next = '0;
            ovf_next = 1'b0;
        end
        else
        begin
            if (ctl.cmp_inc && cmp_reg != TOT_MAX)
            begin
                cmp_next = cmp_reg + 1'b1;
            end
            if (ctl.mov_inc && mov_reg != TOT_MAX)
            begin
                mov_next = mov_reg + 1'b1;
            end
            if (ctl.ovf_set)
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_reg <= '0;
            mov_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            cmp_reg <= cmp_next;
            mov_reg <= mov_next;
            ovf_reg <= ovf_next;
        end
    end

    assign compare_total = cmp_reg;
    assign move_total    = mov_reg;
    assign overflow      = ovf_reg;

endmodule

>>> sv/insertion_sort_counted_top.sv
// channel | signals                                         | handshake
// --------+-------------------------------------------------+-------------------------
// in      | value, last                                     | start & !busy
// out     | sorted_value, is_final, compare_total,          | strobe, one cycle each
//         | move_total, overflow                            |
//
// A word goes in when start is high and busy is low. Storing the first word of a set,
// or dropping a word when the store is full, needs no compare. Otherwise insertion shifts
// larger entries up until its place is found, one compare and one shift per cycle.
// A word marked last then emits n results on consecutive cycles.
// Reset clears the count, totals and state; store contents are not cleared.
// The receiver cannot stall; busy stays high until the last result has gone out.
module insertion_sort_counted_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [isc_pkg::DATA_W-1:0] value,
    input  logic                              last,
    output logic                              strobe,
    output logic signed [isc_pkg::DATA_W-1:0] sorted_value,
    output logic                              is_final,
    output logic [isc_pkg::TOT_W-1:0]         compare_total,
    output logic [isc_pkg::TOT_W-1:0]         move_total,
    output logic                              overflow
);
    import isc_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [IDX_W-1:0]  k_reg;
    logic [DATA_W-1:0] val_reg;
    logic              last_reg;
    logic              strobe_reg;
    logic              final_reg;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;

    logic              n_inc;
    logic              emit_issue;
    logic              greater;
    logic              k_end;
    logic [CNT_W-1:0]  n_m1;
    logic [CNT_W-1:0]  pos_m1;
    logic [CNT_W-1:0]  pos_m2;
    stats_ctl_t        ctl;

    assign greater = $signed(rd_data) > $signed(val_reg);
    assign n_m1    = n_reg - 1'b1;
    assign pos_m1  = pos_reg - 1'b1;
    assign pos_m2  = pos_reg - CNT_W'(2);
    assign k_end   = {1'b0, k_reg} == n_m1;

    isc_ram #(
        .DATA_W (DATA_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    isc_stats u_stats (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .compare_total (compare_total),
        .move_total    (move_total),
        .overflow      (overflow)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (n_reg == CNT_MAX || n_reg == '0)
                    begin
                        state_next = last ? ST_EMIT : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_CMP;
                    end
                end
            end
            ST_CMP:
            begin
                if (greater)
                begin
                    state_next = (pos_reg == CNT_ONE) ? ST_PLACE : ST_CMP;
                end
                else
                begin
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_PLACE:
            begin
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                state_next = k_end ? ST_DONE : ST_EMIT;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        wr_en      = 1'b0;
        wr_addr    = pos_reg[IDX_W-1:0];
        wr_data    = val_reg;
        rd_en      = 1'b0;
        rd_addr    = k_reg;
        n_inc      = 1'b0;
        emit_issue = 1'b0;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (n_reg == CNT_MAX)
                    begin
                        ctl.ovf_set = 1'b1;
                    end
                    else if (n_reg == '0)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        wr_data = value;
                        n_inc   = 1'b1;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = n_m1[IDX_W-1:0];
                    end
                end
            end
            ST_CMP:
            begin
                ctl.cmp_inc = 1'b1;
                ctl.mov_inc = 1'b1;
                wr_en       = 1'b1;
                if (greater)
                begin
                    wr_data = rd_data;
                    if (pos_reg != CNT_ONE)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = pos_m2[IDX_W-1:0];
                    end
                end
                else
                begin
                    n_inc = 1'b1;
                end
            end
            ST_PLACE:
            begin
                wr_en       = 1'b1;
                wr_addr     = '0;
                ctl.mov_inc = 1'b1;
                n_inc       = 1'b1;
            end
            ST_EMIT:
            begin
                rd_en      = 1'b1;
                emit_issue = 1'b1;
            end
            ST_DONE:
            begin
                ctl.clear = 1'b1;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            n_reg      <= '0;
            strobe_reg <= 1'b0;
            final_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= emit_issue;
            final_reg  <= emit_issue && k_end;
            if (ctl.clear)
            begin
                n_reg <= '0;
            end
            else if (n_inc)
            begin
                n_reg <= n_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            val_reg  <= value;
            last_reg <= last;
            pos_reg  <= n_reg;
            k_reg    <= '0;
        end
        else if (state_reg == ST_CMP && greater)
        begin
            pos_reg <= pos_m1;
        end
        else if (state_reg == ST_EMIT)
        begin
            k_reg <= k_reg + 1'b1;
        end
    end

    assign busy         = state_reg != ST_IDLE;
    assign strobe       = strobe_reg;
    assign is_final     = final_reg;
    assign sorted_value = rd_data;

endmodule
